// ===== rtl/core/sprx_pkg.sv =====
// ----------------------------------------------------------------------------
// sprx_pkg
// shared types and constants of the serial port receive block: item kinds,
// register offsets, write masks and status flag layout
// ----------------------------------------------------------------------------
package sprx_pkg;

    // item kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_RXB   = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    // register offsets
    localparam logic [5:0] OFF_MODE    = 6'h00;
    localparam logic [5:0] OFF_BAUD    = 6'h04;
    localparam logic [5:0] OFF_CTRL    = 6'h08;
    localparam logic [5:0] OFF_TXDATA  = 6'h0c;
    localparam logic [5:0] OFF_STATUS  = 6'h10;
    localparam logic [5:0] OFF_RXDATA  = 6'h14;
    localparam logic [5:0] OFF_FCR     = 6'h18;
    localparam logic [5:0] OFF_RXCOUNT = 6'h1c;
    localparam logic [5:0] OFF_PORT    = 6'h20;
    localparam logic [5:0] OFF_RSVD    = 6'h24;

    // write masks
    localparam logic [7:0] MODE_MASK_FIFO  = 8'h7b;
    localparam logic [7:0] MODE_MASK_PLAIN = 8'hff;
    localparam logic [7:0] CTRL_MASK_FIFO  = 8'hfa;
    localparam logic [7:0] CTRL_MASK_PLAIN = 8'hff;
    localparam logic [7:0] PORT_MASK_FIFO  = 8'hf3;
    localparam logic [7:0] PORT_MASK_PLAIN = 8'h8f;

    // control register bits
    localparam int CTRL_RE  = 4;
    localparam int CTRL_TE  = 5;
    localparam int CTRL_RIE = 6;
    localparam int CTRL_TIE = 7;

    // status register bits as seen on the bus
    localparam int SR_TEND = 6;
    localparam int SR_TDE  = 5;
    localparam int SR_BRK  = 4;
    localparam int SR_RDF  = 1;
    localparam int SR_DR   = 0;

    // reset values
    localparam logic [7:0] CTRL_RESET    = 8'h20;
    localparam logic [7:0] TIMEOUT_RESET = 8'd15;

    // configuration register indexes
    localparam logic CFG_SCIF_MODE     = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    // status flags kept in the block (break is never raised)
    typedef struct packed {
        logic tend;
        logic tde;
        logic rdf;
        logic dr;
    } sprx_flags_t;

    // receive trigger level from fifo control bits 7:6
    function automatic logic [7:0] sprx_trigger(input logic [1:0] rtrg);
        logic [7:0] lvl;
        case (rtrg)
            2'd0: lvl = 8'd1;
            2'd1: lvl = 8'd4;
            2'd2: lvl = 8'd8;
            default: lvl = 8'd14;
        endcase
        return lvl;
    endfunction

endpackage

// ===== rtl/core/serial_port_rx_fifo_registers_top.sv =====
// ----------------------------------------------------------------------------
// serial_port_rx_fifo_registers_top
// register-mapped serial port with a receive fifo, timeout and interrupts
// ----------------------------------------------------------------------------
//
//  channel | ports                        | direction | beat
//  --------+------------------------------+-----------+-------------------------
//  s_      | s_valid/s_ready + fields     | in        | read, write, rx byte, tick
//  m_      | m_valid/m_ready + fields     | out       | one result per input beat
//  cfg_    | cfg_valid/cfg_ready + idx/data| in       | mode and timeout setup
//
// one beat per cycle while s_ready is high: the whole register/fifo update
// is one pass of logic between the accepted beat and the result register,
// the fifo read port is registered alongside the result.
// s_ready is high whenever the result register is empty or being drained,
// so a stall on m_ready only holds the input side while a result waits.
// synchronous active-low reset; the fifo storage itself is not cleared,
// entries are only read after being written.
module serial_port_rx_fifo_registers_top
    import sprx_pkg::*;
#(
    parameter int RX_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [5:0]  s_reg_offset,
    input  logic [15:0] s_write_data,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_read_data,
    output logic        m_access_error,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_rx_overrun,
    output logic        m_rx_ready,
    output logic        m_rx_irq,
    output logic        m_tx_irq
);

    localparam int PTR_W = $clog2(RX_DEPTH);
    localparam int CNT_W = $clog2(RX_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RX_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RX_DEPTH);

    // configuration
    logic        scif_mode_reg;
    logic [7:0]  timeout_ticks_reg;

    // register file and receive state
    logic [7:0]  mode_reg,     mode_next;
    logic [7:0]  control_reg,  control_next;
    logic [15:0] fcr_reg,      fcr_next;
    logic [7:0]  port_reg,     port_next;
    sprx_flags_t flags_reg,    flags_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [7:0]  tmo_left_reg, tmo_left_next;
    logic        tmo_armed_reg, tmo_armed_next;
    logic        rx_irq_reg,   rx_irq_next;
    logic        tx_irq_reg,   tx_irq_next;

    // receive fifo storage
    logic [7:0]       rx_mem [RX_DEPTH];
    logic [7:0]       mem_q_reg;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;

    // result register
    logic        m_valid_reg;
    logic        rd_fifo_reg,  rd_fifo_next;
    logic [15:0] rdata_reg,    rdata_next;
    logic        err_reg,      err_next;
    logic        txv_reg,      txv_next;
    logic [7:0]  txb_reg,      txb_next;
    logic        ovr_reg,      ovr_next;
    logic        rxrdy_next;

    logic        accept;
    logic [7:0]  trig;
    logic [7:0]  cnt_ext;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign trig      = sprx_trigger(fcr_reg[7:6]);

    // one pass over the beat: next register state and the result fields
    always_comb begin
        mode_next      = mode_reg;
        control_next   = control_reg;
        fcr_next       = fcr_reg;
        port_next      = port_reg;
        flags_next     = flags_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        tmo_left_next  = tmo_left_reg;
        tmo_armed_next = tmo_armed_reg;
        rx_irq_next    = rx_irq_reg;
        tx_irq_next    = tx_irq_reg;
        rd_fifo_next   = 1'b0;
        rdata_next     = 16'h0000;
        err_next       = 1'b0;
        txv_next       = 1'b0;
        txb_next       = 8'h00;
        ovr_next       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = wr_ptr_reg;
        cnt_ext        = 8'(count_reg);

        case (s_kind)
            KIND_READ: begin
                if (!scif_mode_reg) begin
                    if (s_reg_offset == OFF_RXCOUNT) begin
                        rdata_next = {8'h00, port_reg};
                    end else begin
                        err_next = 1'b1;
                    end
                end else begin
                    case (s_reg_offset)
                        OFF_MODE: rdata_next = {8'h00, mode_reg};
                        OFF_CTRL: rdata_next = {8'h00, control_reg};
                        OFF_STATUS: begin
                            rdata_next[SR_TEND] = flags_reg.tend;
                            rdata_next[SR_TDE]  = flags_reg.tde;
                            rdata_next[SR_RDF]  = flags_reg.rdf;
                            rdata_next[SR_DR]   = flags_reg.dr;
                            if (control_reg[CTRL_TE]) begin
                                flags_next.tde  = 1'b1;
                                flags_next.tend = 1'b1;
                            end
                        end
                        OFF_RXDATA: begin
                            if (count_reg == '0) begin
                                err_next = 1'b1;
                            end else begin
                                // data comes from the registered fifo read port
                                rd_fifo_next = 1'b1;
                                rd_ptr_next  = (rd_ptr_reg == LAST_PTR) ? '0
                                             : rd_ptr_reg + 1'b1;
                                count_next   = count_reg - 1'b1;
                                cnt_ext      = 8'(count_next);
                                if (cnt_ext < trig) begin
                                    flags_next.rdf = 1'b0;
                                end
                            end
                        end
                        OFF_FCR:     rdata_next = fcr_reg;
                        OFF_RXCOUNT: rdata_next = 16'(count_reg);
                        OFF_PORT:    rdata_next = {8'h00, port_reg};
                        OFF_RSVD:    rdata_next = 16'h0000;
                        default:     err_next   = 1'b1;
                    endcase
                end
            end

            KIND_WRITE: begin
                case (s_reg_offset)
                    OFF_MODE: begin
                        mode_next = s_write_data[7:0]
                                  & (scif_mode_reg ? MODE_MASK_FIFO : MODE_MASK_PLAIN);
                    end
                    OFF_BAUD: begin
                        // baud divisor has no effect on the item level
                    end
                    OFF_CTRL: begin
                        control_next = s_write_data[7:0]
                                     & (scif_mode_reg ? CTRL_MASK_FIFO : CTRL_MASK_PLAIN);
                        if (!s_write_data[CTRL_TE]) begin
                            flags_next.tend = 1'b1;
                        end
                        if (scif_mode_reg) begin
                            tx_irq_next = s_write_data[CTRL_TIE];
                        end
                        if (!s_write_data[CTRL_RIE]) begin
                            rx_irq_next = 1'b0;
                        end
                    end
                    OFF_TXDATA: begin
                        flags_next.tde = 1'b0;
                        txv_next       = 1'b1;
                        txb_next       = s_write_data[7:0];
                    end
                    OFF_STATUS: begin
                        if (!scif_mode_reg) begin
                            err_next = 1'b1;
                        end else begin
                            // write zero to clear
                            if (!s_write_data[SR_TEND]) flags_next.tend = 1'b0;
                            if (!s_write_data[SR_TDE])  flags_next.tde  = 1'b0;
                            if (!s_write_data[SR_RDF])  flags_next.rdf  = 1'b0;
                            if (!s_write_data[SR_DR])   flags_next.dr   = 1'b0;
                            if (!s_write_data[SR_RDF] || !s_write_data[SR_DR]) begin
                                rx_irq_next = 1'b0;
                            end
                        end
                    end
                    OFF_FCR: begin
                        if (!scif_mode_reg) begin
                            err_next = 1'b1;
                        end else begin
                            fcr_next = s_write_data;
                            if (s_write_data[1]) begin
                                count_next  = '0;
                                rd_ptr_next = '0;
                                wr_ptr_next = '0;
                            end
                        end
                    end
                    OFF_RXCOUNT: begin
                        if (scif_mode_reg) begin
                            err_next = 1'b1;
                        end else begin
                            port_next = s_write_data[7:0] & PORT_MASK_PLAIN;
                        end
                    end
                    OFF_PORT: begin
                        if (!scif_mode_reg) begin
                            err_next = 1'b1;
                        end else begin
                            port_next = s_write_data[7:0] & PORT_MASK_FIFO;
                        end
                    end
                    OFF_RSVD: begin
                        err_next = !scif_mode_reg;
                    end
                    default: err_next = 1'b1;
                endcase
            end

            KIND_RXB: begin
                if (control_reg[CTRL_RE]) begin
                    if (!scif_mode_reg) begin
                        // plain variant keeps only the last byte in entry 0
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                    end else if (count_reg == FULL_CNT) begin
                        ovr_next = 1'b1;
                    end else begin
                        mem_we      = 1'b1;
                        wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
                        count_next  = count_reg + 1'b1;
                        cnt_ext     = 8'(count_next);
                        if (cnt_ext >= trig) begin
                            flags_next.rdf = 1'b1;
                            if (control_reg[CTRL_RIE]) begin
                                tmo_armed_next = 1'b0;
                                tmo_left_next  = 8'h00;
                                rx_irq_next    = 1'b1;
                            end
                        end else begin
                            tmo_left_next  = timeout_ticks_reg;
                            tmo_armed_next = 1'b1;
                        end
                    end
                end
            end

            KIND_TICK: begin
                if (tmo_armed_reg) begin
                    if (tmo_left_reg <= 8'd1) begin
                        tmo_left_next  = 8'h00;
                        tmo_armed_next = 1'b0;
                        flags_next.dr  = 1'b1;
                        if (control_reg[CTRL_RIE]) begin
                            rx_irq_next = 1'b1;
                        end
                    end else begin
                        tmo_left_next = tmo_left_reg - 1'b1;
                    end
                end
            end

            default: begin
            end
        endcase

        rxrdy_next = control_next[CTRL_RE] && (count_next != FULL_CNT);
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scif_mode_reg     <= 1'b1;
            timeout_ticks_reg <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SCIF_MODE:     scif_mode_reg     <= cfg_data[0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 8'h00;
            control_reg   <= CTRL_RESET;
            fcr_reg       <= 16'h0000;
            port_reg      <= 8'h00;
            flags_reg     <= '{tend: 1'b1, tde: 1'b1, rdf: 1'b0, dr: 1'b0};
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            tmo_left_reg  <= 8'h00;
            tmo_armed_reg <= 1'b0;
            rx_irq_reg    <= 1'b0;
            tx_irq_reg    <= 1'b0;
        end else if (accept) begin
            mode_reg      <= mode_next;
            control_reg   <= control_next;
            fcr_reg       <= fcr_next;
            port_reg      <= port_next;
            flags_reg     <= flags_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            tmo_left_reg  <= tmo_left_next;
            tmo_armed_reg <= tmo_armed_next;
            rx_irq_reg    <= rx_irq_next;
            tx_irq_reg    <= tx_irq_next;
        end
    end

    // fifo storage: one write port, one registered read port at the head
    always_ff @(posedge aclk) begin
        if (accept && mem_we) begin
            rx_mem[mem_waddr] <= s_rx_byte;
        end
        if (accept) begin
            mem_q_reg <= rx_mem[rd_ptr_reg];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_fifo_reg    <= rd_fifo_next;
            rdata_reg      <= rdata_next;
            err_reg        <= err_next;
            txv_reg        <= txv_next;
            txb_reg        <= txb_next;
            ovr_reg        <= ovr_next;
            m_rx_ready     <= rxrdy_next;
            m_rx_irq       <= rx_irq_next;
            m_tx_irq       <= tx_irq_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_read_data    = rd_fifo_reg ? {8'h00, mem_q_reg} : rdata_reg;
    assign m_access_error = err_reg;
    assign m_tx_valid     = txv_reg;
    assign m_tx_byte      = txb_reg;
    assign m_rx_overrun   = ovr_reg;

endmodule

// ===== tb/tb_serial_port_rx_fifo_registers_top.sv =====
// ----------------------------------------------------------------------------
// tb_serial_port_rx_fifo_registers_top
// self-checking bench for the register-mapped serial port with receive fifo.
// a behavioral copy of the register file, status flags, receive fifo, timer
// and interrupt lines predicts one result per accepted input beat. every
// result beat is compared field by field against the oldest prediction.
// stimulus is a short directed pass, then register and line traffic in
// several mode and timeout settings, with random gaps on either side in most.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_serial_port_rx_fifo_registers_top
    import sprx_pkg::*;
();

    localparam int RX_DEPTH     = 16;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int MAX_REPORTS  = 10;
    localparam int MAX_GAP      = 12;
    localparam int FCR_RX_RESET = 1;     // fifo control bit that empties the fifo

    // one input beat as the block sees it
    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  offset;
        logic [15:0] wdata;
        logic [7:0]  rxb;
    } port_item_t;

    // one result beat, same field order as the m_ ports
    typedef struct packed {
        logic [15:0] read_data;
        logic        access_error;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        rx_overrun;
        logic        rx_ready;
        logic        rx_irq;
        logic        tx_irq;
    } port_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [5:0]  s_reg_offset;
    logic [15:0] s_write_data;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_read_data;
    logic        m_access_error;
    logic        m_tx_valid;
    logic [7:0]  m_tx_byte;
    logic        m_rx_overrun;
    logic        m_rx_ready;
    logic        m_rx_irq;
    logic        m_tx_irq;

    serial_port_rx_fifo_registers_top #(
        .RX_DEPTH(RX_DEPTH)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_reg_offset  (s_reg_offset),
        .s_write_data  (s_write_data),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_access_error(m_access_error),
        .m_tx_valid    (m_tx_valid),
        .m_tx_byte     (m_tx_byte),
        .m_rx_overrun  (m_rx_overrun),
        .m_rx_ready    (m_rx_ready),
        .m_rx_irq      (m_rx_irq),
        .m_tx_irq      (m_tx_irq)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor state: configuration copy plus everything the block holds
    // ------------------------------------------------------------------------
    logic        mdl_fifo_mode;
    logic [7:0]  mdl_timeout_ticks;
    logic [7:0]  mdl_mode;
    logic [7:0]  mdl_baud;
    logic [7:0]  mdl_ctrl;
    logic [7:0]  mdl_txdata;
    logic [15:0] mdl_fcr;
    logic [7:0]  mdl_port;
    sprx_flags_t mdl_flags;
    logic [7:0]  mdl_rxq [RX_DEPTH];
    int          mdl_rx_count;
    logic [3:0]  mdl_rd_ptr;
    logic [3:0]  mdl_wr_ptr;
    logic [7:0]  mdl_timer;
    logic        mdl_timer_on;
    logic        mdl_rx_irq;
    logic        mdl_tx_irq;

    // expected results, oldest first
    port_result_t pending_results[$];

    // bookkeeping
    int  cycle_count;
    int  mismatch_count;
    int  beats_accepted;
    int  results_checked;
    int  cfg_writes;
    int  overruns_seen;
    int  timeouts_fired;
    int  bytes_popped;

    // stimulus knobs shared with the receiver process
    bit  src_gaps;
    bit  sink_gaps;
    int  sink_hold_cycles;
    int  cur_timeout;

    // receive trigger depth from fifo control bits 7:6
    function automatic int rx_trigger_depth(input logic [1:0] sel);
        case (sel)
            2'd0:    return 1;
            2'd1:    return 4;
            2'd2:    return 8;
            default: return 14;
        endcase
    endfunction

    function automatic void rx_fifo_flush();
        for (int i = 0; i < RX_DEPTH; i++) begin
            mdl_rxq[i] = 8'h00;
        end
        mdl_rx_count = 0;
        mdl_rd_ptr   = '0;
        mdl_wr_ptr   = '0;
    endfunction

    function automatic void port_model_reset();
        mdl_fifo_mode     = 1'b1;
        mdl_timeout_ticks = TIMEOUT_RESET;
        mdl_mode          = 8'h00;
        mdl_baud          = 8'hff;
        mdl_ctrl          = CTRL_RESET;
        mdl_txdata        = 8'hff;
        mdl_fcr           = 16'h0000;
        mdl_port          = 8'h00;
        mdl_flags         = '0;
        mdl_flags.tend    = 1'b1;
        mdl_flags.tde     = 1'b1;
        rx_fifo_flush();
        mdl_timer         = 8'h00;
        mdl_timer_on      = 1'b0;
        mdl_rx_irq        = 1'b0;
        mdl_tx_irq        = 1'b0;
    endfunction

    // applies one accepted beat to the state copy and returns what it produces
    function automatic port_result_t predict_port_beat(input port_item_t it);
        port_result_t r;
        logic [15:0]  v;
        logic         ok;
        r  = '0;
        v  = it.wdata;
        ok = 1'b1;
        case (it.kind)
            KIND_READ: begin
                if (!mdl_fifo_mode) begin
                    // plain variant only exposes the port register
                    if (it.offset == OFF_RXCOUNT) r.read_data = {8'h00, mdl_port};
                    else ok = 1'b0;
                end else begin
                    case (it.offset)
                        OFF_MODE:    r.read_data = {8'h00, mdl_mode};
                        OFF_CTRL:    r.read_data = {8'h00, mdl_ctrl};
                        OFF_STATUS: begin
                            r.read_data[SR_TEND] = mdl_flags.tend;
                            r.read_data[SR_TDE]  = mdl_flags.tde;
                            r.read_data[SR_RDF]  = mdl_flags.rdf;
                            r.read_data[SR_DR]   = mdl_flags.dr;
                            // transmitter enabled: status read re-arms both tx flags
                            if (mdl_ctrl[CTRL_TE]) begin
                                mdl_flags.tde  = 1'b1;
                                mdl_flags.tend = 1'b1;
                            end
                        end
                        OFF_RXDATA: begin
                            if (mdl_rx_count == 0) begin
                                ok = 1'b0;
                            end else begin
                                r.read_data  = {8'h00, mdl_rxq[mdl_rd_ptr]};
                                mdl_rd_ptr   = mdl_rd_ptr + 4'd1;
                                mdl_rx_count = mdl_rx_count - 1;
                                bytes_popped++;
                                if (mdl_rx_count < rx_trigger_depth(mdl_fcr[7:6]))
                                    mdl_flags.rdf = 1'b0;
                            end
                        end
                        OFF_FCR:     r.read_data = mdl_fcr;
                        OFF_RXCOUNT: r.read_data = 16'(mdl_rx_count);
                        OFF_PORT:    r.read_data = {8'h00, mdl_port};
                        OFF_RSVD:    r.read_data = 16'h0000;
                        default:     ok = 1'b0;
                    endcase
                end
            end
            KIND_WRITE: begin
                case (it.offset)
                    OFF_MODE: mdl_mode = v[7:0] & (mdl_fifo_mode ? MODE_MASK_FIFO
                                                                 : MODE_MASK_PLAIN);
                    OFF_BAUD: mdl_baud = v[7:0];
                    OFF_CTRL: begin
                        mdl_ctrl = v[7:0] & (mdl_fifo_mode ? CTRL_MASK_FIFO
                                                           : CTRL_MASK_PLAIN);
                        if (!v[CTRL_TE]) mdl_flags.tend = 1'b1;
                        if (mdl_fifo_mode) mdl_tx_irq = v[CTRL_TIE];
                        if (!v[CTRL_RIE]) mdl_rx_irq = 1'b0;
                    end
                    OFF_TXDATA: begin
                        mdl_txdata    = v[7:0];
                        mdl_flags.tde = 1'b0;
                        r.tx_valid    = 1'b1;
                        r.tx_byte     = v[7:0];
                    end
                    OFF_STATUS: begin
                        if (mdl_fifo_mode) begin
                            // write zero to clear
                            if (!v[SR_TEND]) mdl_flags.tend = 1'b0;
                            if (!v[SR_TDE])  mdl_flags.tde  = 1'b0;
                            if (!v[SR_RDF])  mdl_flags.rdf  = 1'b0;
                            if (!v[SR_DR])   mdl_flags.dr   = 1'b0;
                            if (!v[SR_RDF] || !v[SR_DR]) mdl_rx_irq = 1'b0;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    OFF_FCR: begin
                        if (mdl_fifo_mode) begin
                            mdl_fcr = v;
                            if (v[FCR_RX_RESET]) rx_fifo_flush();
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    OFF_RXCOUNT: begin
                        if (!mdl_fifo_mode) mdl_port = v[7:0] & PORT_MASK_PLAIN;
                        else ok = 1'b0;
                    end
                    OFF_PORT: begin
                        if (mdl_fifo_mode) mdl_port = v[7:0] & PORT_MASK_FIFO;
                        else ok = 1'b0;
                    end
                    OFF_RSVD: begin
                        if (!mdl_fifo_mode) ok = 1'b0;
                    end
                    default: ok = 1'b0;
                endcase
            end
            KIND_RXB: begin
                if (mdl_ctrl[CTRL_RE]) begin
                    if (!mdl_fifo_mode) begin
                        // plain variant parks the byte in entry 0, never readable
                        mdl_rxq[0] = it.rxb;
                    end else if (mdl_rx_count >= RX_DEPTH) begin
                        r.rx_overrun = 1'b1;
                        overruns_seen++;
                    end else begin
                        mdl_rxq[mdl_wr_ptr] = it.rxb;
                        mdl_wr_ptr   = mdl_wr_ptr + 4'd1;
                        mdl_rx_count = mdl_rx_count + 1;
                        if (mdl_rx_count >= rx_trigger_depth(mdl_fcr[7:6])) begin
                            mdl_flags.rdf = 1'b1;
                            if (mdl_ctrl[CTRL_RIE]) begin
                                mdl_timer_on = 1'b0;
                                mdl_timer    = 8'h00;
                                mdl_rx_irq   = 1'b1;
                            end
                        end else begin
                            mdl_timer    = mdl_timeout_ticks;
                            mdl_timer_on = 1'b1;
                        end
                    end
                end
            end
            default: begin
                // character-time tick; a zero load behaves like one tick
                if (mdl_timer_on) begin
                    if (mdl_timer <= 8'd1) begin
                        mdl_timer    = 8'h00;
                        mdl_timer_on = 1'b0;
                        mdl_flags.dr = 1'b1;
                        timeouts_fired++;
                        if (mdl_ctrl[CTRL_RIE]) mdl_rx_irq = 1'b1;
                    end else begin
                        mdl_timer = mdl_timer - 8'd1;
                    end
                end
            end
        endcase
        if (!ok) begin
            r.read_data    = 16'h0000;
            r.access_error = 1'b1;
        end
        r.rx_ready = mdl_ctrl[CTRL_RE] && (mdl_rx_count < RX_DEPTH);
        r.rx_irq   = mdl_rx_irq;
        r.tx_irq   = mdl_tx_irq;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // monitor: predicts on every accepted input beat, then checks any result
    // beat of the same edge against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : port_monitor
        port_item_t   it;
        port_result_t want;
        port_result_t got;
        string        diff;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                cfg_writes++;
                if (cfg_index == CFG_SCIF_MODE) mdl_fifo_mode = cfg_data[0];
                else mdl_timeout_ticks = cfg_data;
            end
            if (s_valid && s_ready) begin
                it = {s_kind, s_reg_offset, s_write_data, s_rx_byte};
                pending_results.push_back(predict_port_beat(it));
                beats_accepted++;
            end
            if (m_valid && m_ready) begin
                got = {m_read_data, m_access_error, m_tx_valid, m_tx_byte,
                       m_rx_overrun, m_rx_ready, m_rx_irq, m_tx_irq};
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] result beat with nothing expected: %h", $realtime, got);
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    diff = "";
                    if (got.read_data    !== want.read_data)    diff = {diff, " read_data"};
                    if (got.access_error !== want.access_error) diff = {diff, " access_error"};
                    if (got.tx_valid     !== want.tx_valid)     diff = {diff, " tx_valid"};
                    if (got.tx_byte      !== want.tx_byte)      diff = {diff, " tx_byte"};
                    if (got.rx_overrun   !== want.rx_overrun)   diff = {diff, " rx_overrun"};
                    if (got.rx_ready     !== want.rx_ready)     diff = {diff, " rx_ready"};
                    if (got.rx_irq       !== want.rx_irq)       diff = {diff, " rx_irq"};
                    if (got.tx_irq       !== want.tx_irq)       diff = {diff, " tx_irq"};
                    if (diff != "") begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("[%0t] result %0d differs in%s", $realtime,
                                     results_checked, diff);
                            $display("    expected rd=%h err=%b txv=%b txb=%h ovr=%b rdy=%b rxi=%b txi=%b",
                                     want.read_data, want.access_error, want.tx_valid,
                                     want.tx_byte, want.rx_overrun, want.rx_ready,
                                     want.rx_irq, want.tx_irq);
                            $display("    actual   rd=%h err=%b txv=%b txb=%h ovr=%b rdy=%b rxi=%b txi=%b",
                                     got.read_data, got.access_error, got.tx_valid,
                                     got.tx_byte, got.rx_overrun, got.rx_ready,
                                     got.rx_irq, got.tx_irq);
                        end
                    end
                end
            end
        end
    end

    // watchdog on total run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result side: random stall per beat, plus long hold-offs on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            // long hold-off, counted here so the sender keeps pushing meanwhile
            if (sink_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge aclk);
                sink_hold_cycles = 0;
            end
            stall = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            // leave on an accepted beat, or early when a hold-off is asked for
            do @(posedge aclk); while (!m_valid && sink_hold_cycles == 0);
        end
    end

    // ------------------------------------------------------------------------
    // input side helpers
    // ------------------------------------------------------------------------

    // offers one beat after a random gap and returns at the edge that takes it;
    // valid stays high so a back-to-back beat never drops it in between
    task automatic send_port_beat(input logic [1:0] kind, input logic [5:0] off,
                                  input logic [15:0] wd, input logic [7:0] rb);
        int gap;
        gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_reg_offset <= off;
        s_write_data <= wd;
        s_rx_byte    <= rb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic reg_read(input logic [5:0] off);
        send_port_beat(KIND_READ, off, 16'($urandom), 8'($urandom));
    endtask

    task automatic reg_write(input logic [5:0] off, input logic [15:0] v);
        send_port_beat(KIND_WRITE, off, v, 8'($urandom));
    endtask

    task automatic line_byte(input logic [7:0] b);
        send_port_beat(KIND_RXB, 6'($urandom), 16'($urandom), b);
    endtask

    task automatic char_tick();
        send_port_beat(KIND_TICK, 6'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // drops valid and waits until every expected result is in, then lets
    // the pipeline settle
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // configuration writes only happen with the block idle
    task automatic set_port_config(input logic idx, input logic [7:0] value);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_TIMEOUT_TICKS) cur_timeout = value;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // every readable register but the receive data straight out of reset, fifo variant
    task automatic test_reset_values();
        reg_read(OFF_MODE);
        reg_read(OFF_CTRL);
        reg_read(OFF_STATUS);
        reg_read(OFF_FCR);
        reg_read(OFF_RXCOUNT);
        reg_read(OFF_PORT);
        reg_read(OFF_RSVD);
    endtask

    // full-scale and zero writes, masks, transmit, unsupported offsets
    task automatic test_register_map();
        reg_write(OFF_MODE, 16'hffff);
        reg_write(OFF_BAUD, 16'hffff);
        reg_write(OFF_CTRL, 16'h00f0);       // rx, tx, both irq enables
        reg_read(OFF_CTRL);
        reg_write(OFF_TXDATA, 16'hffff);
        reg_write(OFF_TXDATA, 16'h0000);
        reg_write(OFF_PORT, 16'hffff);
        reg_write(OFF_RSVD, 16'hffff);
        reg_write(OFF_FCR, 16'h0040);        // trigger at four bytes
        reg_write(OFF_RXDATA, 16'h5555);     // data register is read-only
        reg_write(OFF_RXCOUNT, 16'haaaa);    // port alias only in plain mode
        reg_read(OFF_BAUD);
        reg_read(6'd63);
        reg_read(OFF_RXDATA);                // empty fifo reads as an error
    endtask

    // timeout below trigger, status read and clear, trigger reached, fifo reset
    task automatic test_receive_timeout();
        set_port_config(CFG_TIMEOUT_TICKS, 8'd1);
        line_byte(8'h00);
        line_byte(8'hff);
        char_tick();
        reg_read(OFF_STATUS);
        reg_write(OFF_STATUS, 16'h0000);
        line_byte(8'h5a);
        line_byte(8'ha5);
        reg_read(OFF_RXDATA);
        reg_read(OFF_RXCOUNT);
        reg_write(OFF_FCR, 16'h0002);
    endtask

    // receiver holds off while the line keeps delivering: the input side must
    // stall, then the fifo overflows; afterwards the sender waits for all results
    task automatic test_backpressure();
        set_port_config(CFG_SCIF_MODE, 8'd1);
        set_port_config(CFG_TIMEOUT_TICKS, 8'd15);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        reg_write(OFF_CTRL, 16'h0070);
        reg_write(OFF_FCR, 16'h00c2);        // trigger fourteen, fifo emptied
        sink_hold_cycles = 90;
        for (int i = 0; i < 24; i++) line_byte(8'($urandom));
        wait_drain();
        for (int i = 0; i < 18; i++) reg_read(OFF_RXDATA);
        reg_read(OFF_STATUS);
    endtask

    // one random sequence of well-formed traffic, occasionally noise
    task automatic random_sequence();
        int          sel;
        int          len;
        logic [15:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            // line burst, long enough to overflow now and then
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++) begin
                line_byte(8'($urandom));
                if ($urandom_range(0, 4) == 0) char_tick();
            end
        end else if (sel < 50) begin
            // drain, sometimes past empty
            len = $urandom_range(1, 18);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 7))
                    0:       reg_read(OFF_RXCOUNT);
                    1:       reg_read(OFF_STATUS);
                    default: reg_read(OFF_RXDATA);
                endcase
            end
        end else if (sel < 62) begin
            // tick run, sometimes long enough for the timer to fire
            if ($urandom_range(0, 5) == 0) len = $urandom_range(1, cur_timeout + 2);
            else len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++) char_tick();
        end else if (sel < 72) begin
            reg_read(OFF_STATUS);
            v = 16'($urandom);
            if ($urandom_range(0, 1) == 0) v = 16'hffff & ~(16'(1) << $urandom_range(0, 1));
            reg_write(OFF_STATUS, v);
        end else if (sel < 80) begin
            if ($urandom_range(0, 1) == 0) begin
                v = 16'($urandom);
                if ($urandom_range(0, 6) != 0) v[CTRL_RE] = 1'b1;
                reg_write(OFF_CTRL, v);
            end else begin
                v = 16'($urandom);
                if ($urandom_range(0, 3) != 0) v[FCR_RX_RESET] = 1'b0;
                reg_write(OFF_FCR, v);
            end
        end else if (sel < 88) begin
            // any mapped register, read or write
            case ($urandom_range(0, 9))
                0: v[5:0] = OFF_MODE;
                1: v[5:0] = OFF_BAUD;
                2: v[5:0] = OFF_CTRL;
                3: v[5:0] = OFF_TXDATA;
                4: v[5:0] = OFF_STATUS;
                5: v[5:0] = OFF_RXDATA;
                6: v[5:0] = OFF_FCR;
                7: v[5:0] = OFF_RXCOUNT;
                8: v[5:0] = OFF_PORT;
                default: v[5:0] = OFF_RSVD;
            endcase
            if ($urandom_range(0, 1) == 0) reg_read(v[5:0]);
            else reg_write(v[5:0], 16'($urandom));
        end else begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                send_port_beat(2'($urandom), 6'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    // one setting of mode and timeout, receiver enabled, then random traffic
    task automatic random_phase(input logic fifo_mode, input logic [7:0] ticks,
                                input int beats, input bit src_idle, input bit sink_idle);
        int target;
        set_port_config(CFG_SCIF_MODE, {7'd0, fifo_mode});
        set_port_config(CFG_TIMEOUT_TICKS, ticks);
        src_gaps  = src_idle;
        sink_gaps = sink_idle;
        reg_write(OFF_CTRL, 16'h0070);
        target = beats_accepted + beats;
        while (beats_accepted < target) random_sequence();
    endtask

    task automatic test_random_traffic();
        random_phase(1'b1, 8'd1,              300, 1'b1, 1'b1);
        random_phase(1'b1, 8'd255,            250, 1'b0, 1'b0);
        random_phase(1'b0, 8'd3,              250, 1'b1, 1'b1);
        random_phase(1'b1, 8'($urandom_range(1, 255)), 350, 1'b1, 1'b0);
        random_phase(1'b0, 8'd255,            150, 1'b0, 1'b1);
        random_phase(1'b1, 8'd8,              350, 1'b1, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_SCIF_MODE;
        cfg_data         = 8'h00;
        s_valid          = 1'b0;
        s_kind           = KIND_READ;
        s_reg_offset     = OFF_MODE;
        s_write_data     = 16'h0000;
        s_rx_byte        = 8'h00;
        cycle_count      = 0;
        mismatch_count   = 0;
        beats_accepted   = 0;
        results_checked  = 0;
        cfg_writes       = 0;
        overruns_seen    = 0;
        timeouts_fired   = 0;
        bytes_popped     = 0;
        sink_hold_cycles = 0;
        cur_timeout      = TIMEOUT_RESET;
        src_gaps         = 1'b1;
        sink_gaps        = 1'b1;
        port_model_reset();

        // single synchronous reset at the start
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_register_map();
        test_receive_timeout();
        test_backpressure();
        test_random_traffic();

        wait_drain();
        $display("covered %0d beats and %0d config writes in both variants", beats_accepted,
                 cfg_writes);
        $display("%0d bytes popped, %0d overruns, %0d receive timeouts, %0d mismatches",
                 bytes_popped, overruns_seen, timeouts_fired, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
